// ===== rtl/wsd_pkg.sv =====
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

	// Header parse phases, one-hot
	typedef enum logic [5:0] {
		PH_HDR0    = 6'b000001,
		PH_HDR1    = 6'b000010,
		PH_EXTLEN  = 6'b000100,
		PH_MASK    = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_CLOSED  = 6'b100000
	} phase_t;

	localparam logic [3:0] OP_CLOSE   = 4'h8;
	localparam logic [6:0] LEN_EXT16  = 7'd126;
	localparam logic [6:0] LEN_EXT64  = 7'd127;
	localparam logic [3:0] EXT16_CNT  = 4'd2;
	localparam logic [3:0] EXT64_CNT  = 4'd8;
	localparam logic [3:0] KEY_CNT    = 4'd4;

	// Input word
	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_t;

	// Result word
	typedef struct packed {
		logic       has_byte;
		logic [7:0] payload_byte;
		logic [3:0] frame_opcode;
		logic       frame_end;
		logic       closed;
	} res_t;

	// Queue entry: raw byte and its key byte, unmasked in the back end
	typedef struct packed {
		logic       has_byte;
		logic [7:0] raw_byte;
		logic [7:0] key_byte;
		logic [3:0] opcode;
		logic       frame_end;
		logic       closed;
	} q_entry_t;

	// Queue status
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== rtl/wsd_chan_if.sv =====
// Valid/ready channel interface carrying one word of a given type.
interface wsd_chan_if #(parameter type payload_t = logic [7:0]);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/wsd_front.sv =====
// Front end: accepts stream bytes, parses frame headers, queues payload work.
module wsd_front (
	input  logic                clk,
	input  logic                arst_n,
	wsd_chan_if.sink            stream,
	input  wsd_pkg::q_stat_t    q_stat,
	output logic                q_push,
	output wsd_pkg::q_entry_t   q_entry
);

	wsd_pkg::phase_t phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        mask_q, mask_d;
	logic [63:0] remain_q, remain_d;
	logic [3:0]  hdr_cnt_q, hdr_cnt_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  pos_q, pos_d;

	logic       accept;
	logic [7:0] b;
	logic       hdr_done;
	logic       start;
	logic       last;
	logic [7:0] key_byte;

	assign stream.ready = !q_stat.full;
	assign accept       = stream.valid && stream.ready;
	assign b            = stream.payload.rx_byte;

	// Key byte for the current payload position, first key byte on top
	always_comb begin
		case (pos_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	assign last = (remain_q == 64'd1);

	// Parser next state
	always_comb begin
		phase_d   = phase_q;
		opcode_d  = opcode_q;
		mask_d    = mask_q;
		remain_d  = remain_q;
		hdr_cnt_d = hdr_cnt_q;
		key_d     = key_q;
		pos_d     = pos_q;
		hdr_done  = 1'b0;
		start     = 1'b0;
		q_push    = 1'b0;
		q_entry   = '0;
		if (accept) begin
			case (phase_q)
				wsd_pkg::PH_HDR0: begin
					opcode_d = b[3:0];
					phase_d  = wsd_pkg::PH_HDR1;
				end
				wsd_pkg::PH_HDR1: begin
					mask_d = b[7];
					if (b[6:0] == wsd_pkg::LEN_EXT16 || b[6:0] == wsd_pkg::LEN_EXT64) begin
						hdr_cnt_d = (b[6:0] == wsd_pkg::LEN_EXT16) ?
							wsd_pkg::EXT16_CNT : wsd_pkg::EXT64_CNT;
						remain_d  = '0;
						phase_d   = wsd_pkg::PH_EXTLEN;
					end else begin
						remain_d = {57'd0, b[6:0]};
						hdr_done = 1'b1;
					end
				end
				wsd_pkg::PH_EXTLEN: begin
					remain_d  = {remain_q[55:0], b};
					hdr_cnt_d = hdr_cnt_q - 4'd1;
					hdr_done  = (hdr_cnt_q == 4'd1);
				end
				wsd_pkg::PH_MASK: begin
					key_d     = {key_q[23:0], b};
					hdr_cnt_d = hdr_cnt_q - 4'd1;
					start     = (hdr_cnt_q == 4'd1);
				end
				wsd_pkg::PH_PAYLOAD: begin
					pos_d              = pos_q + 2'd1;
					remain_d           = remain_q - 64'd1;
					q_push             = 1'b1;
					q_entry.has_byte   = 1'b1;
					q_entry.raw_byte   = b;
					q_entry.key_byte   = mask_q ? key_byte : 8'd0;
					q_entry.opcode     = opcode_q;
					q_entry.frame_end  = last;
					q_entry.closed     = last && (opcode_q == wsd_pkg::OP_CLOSE);
					if (last) begin
						phase_d = (opcode_q == wsd_pkg::OP_CLOSE) ?
							wsd_pkg::PH_CLOSED : wsd_pkg::PH_HDR0;
					end
				end
				wsd_pkg::PH_CLOSED: begin
					phase_d = wsd_pkg::PH_CLOSED;
				end
				default: begin
					phase_d = wsd_pkg::PH_HDR0;
				end
			endcase

			// Length complete: mask key next, or header complete without one
			if (hdr_done) begin
				if (mask_d) begin
					hdr_cnt_d = wsd_pkg::KEY_CNT;
					key_d     = '0;
					phase_d   = wsd_pkg::PH_MASK;
				end else begin
					start = 1'b1;
				end
			end

			// Header complete: empty frame ends here, else payload follows
			if (start) begin
				pos_d = 2'd0;
				if (remain_d == 64'd0) begin
					q_push            = 1'b1;
					q_entry.opcode    = opcode_q;
					q_entry.frame_end = 1'b1;
					q_entry.closed    = (opcode_q == wsd_pkg::OP_CLOSE);
					phase_d = (opcode_q == wsd_pkg::OP_CLOSE) ?
						wsd_pkg::PH_CLOSED : wsd_pkg::PH_HDR0;
				end else begin
					phase_d = wsd_pkg::PH_PAYLOAD;
				end
			end
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= wsd_pkg::PH_HDR0;
			opcode_q  <= '0;
			mask_q    <= 1'b0;
			hdr_cnt_q <= '0;
			pos_q     <= '0;
		end else begin
			phase_q   <= phase_d;
			opcode_q  <= opcode_d;
			mask_q    <= mask_d;
			hdr_cnt_q <= hdr_cnt_d;
			pos_q     <= pos_d;
		end
	end

	// Length and key registers
	always_ff @(posedge clk) begin
		remain_q <= remain_d;
		key_q    <= key_d;
	end

endmodule

// ===== rtl/wsd_queue.sv =====
// Small FIFO of payload work between the header parser and the output stage.
module wsd_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wsd_pkg::q_entry_t push_entry,
	input  logic              pop,
	output wsd_pkg::q_entry_t head,
	output wsd_pkg::q_stat_t  stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	wsd_pkg::q_entry_t store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = store_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/wsd_back.sv =====
// Back end: unmasks queued bytes into the registered result channel.
module wsd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  wsd_pkg::q_entry_t head,
	input  wsd_pkg::q_stat_t  q_stat,
	output logic              pop,
	wsd_chan_if.source        result
);

	logic          valid_q;
	wsd_pkg::res_t data_q;

	// Load when the output register is free or being taken
	assign pop = !q_stat.empty && (!valid_q || result.ready);

	assign result.valid   = valid_q;
	assign result.payload = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result word, unmasked
	always_ff @(posedge clk) begin
		if (pop) begin
			data_q.has_byte     <= head.has_byte;
			data_q.payload_byte <= head.raw_byte ^ head.key_byte;
			data_q.frame_opcode <= head.opcode;
			data_q.frame_end    <= head.frame_end;
			data_q.closed       <= head.closed;
		end
	end

endmodule

// ===== rtl/websocket_frame_deframer_core.sv =====
// WebSocket frame deframer: byte stream in, unmasked payload words out.
//
// Channels: stream carries one received byte per word (rx_byte); result
// carries one word per payload byte (has_byte, payload_byte, frame_opcode,
// frame_end, closed), plus one word with has_byte low for an empty frame.
// Header bytes give no result word. Both use valid/ready.
// Throughput: one byte per cycle, sustained while the queue is not full, with
// the header parser and the 64-bit remaining-length decrement in every step.
// A payload byte accepted on stream is written into the queue, then loaded
// into the output register, before it appears on result.
// The parser and the output register are decoupled by a DEPTH-entry queue;
// stream.ready drops only when that queue is full, so a stalled receiver
// backs up through the queue and then halts byte intake.
// After a close frame completes, bytes are still accepted but dropped.
// Reset: asynchronous, active low; the parser waits for a first header byte
// and the queue and output register are emptied.
module websocket_frame_deframer_core #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	wsd_chan_if.sink   stream,
	wsd_chan_if.source result
);

	logic              q_push;
	logic              q_pop;
	wsd_pkg::q_entry_t q_entry;
	wsd_pkg::q_entry_t q_head;
	wsd_pkg::q_stat_t  q_stat;

	wsd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream),
		.q_stat  (q_stat),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	wsd_queue #(.DEPTH(DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.head       (q_head),
		.stat       (q_stat)
	);

	wsd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.q_stat (q_stat),
		.pop    (q_pop),
		.result (result)
	);

	// Parser never writes a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !q_push)
		else $error("queue write while full");

	// Close is only flagged on a frame's last word
	a_closed_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.payload.closed |-> result.payload.frame_end)
		else $error("closed without frame_end");

	// Word without a byte is an empty-frame end with a zero byte
	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.payload.has_byte |->
			result.payload.frame_end && result.payload.payload_byte == 8'd0)
		else $error("malformed empty-frame word");

	// Nothing follows the close word
	a_silent_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && result.payload.closed |=> !result.valid)
		else $error("result after close");

endmodule
